FILE: hdl/i2c_bit_level_master_unit_macros.svh
// ---------------------------------------------------------------------------
// I2C bit-level master assertion macros
// Shared concurrent assertion forms for the port checker.
// ---------------------------------------------------------------------------
`ifndef I2C_BIT_LEVEL_MASTER_UNIT_MACROS_SVH
`define I2C_BIT_LEVEL_MASTER_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define I2CBM_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("i2cbm assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define I2CBM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("i2cbm assertion failed");

`endif

FILE: hdl/i2cbm_pkg.sv
// ---------------------------------------------------------------------------
// I2C bit-level master package
// Operation codes, register indexes, constants and shared structures.
// ---------------------------------------------------------------------------
package i2cbm_pkg;

    localparam int PHASE_W = 5;

    // The tick code doubles as the idle marker of the active sequence.
    typedef enum logic [3:0] {
        OP_TICK  = 4'd0,
        OP_START = 4'd1,
        OP_STOP  = 4'd2,
        OP_ACK   = 4'd3,
        OP_NACK  = 4'd4,
        OP_WAIT  = 4'd5,
        OP_SEND  = 4'd6,
        OP_RECV  = 4'd7,
        OP_RESET = 4'd8
    } op_t;

    typedef enum logic [0:0] {
        CFG_ACK_WAIT_LIMIT    = 1'b0,
        CFG_RESET_CLOCK_LIMIT = 1'b1
    } cfg_idx_t;

    localparam logic [PHASE_W-1:0] SEND_LAST_PHASE = 5'd24;
    localparam logic [PHASE_W-1:0] RECV_LAST_PHASE = 5'd15;
    localparam logic [7:0]         ACK_WAIT_RESET  = 8'd5;
    localparam logic [3:0]         RESET_CLK_RESET = 4'd9;
    localparam logic [1:0]         SUB_LAST        = 2'd2;

    typedef struct packed {
        logic [3:0] operation;
        logic [7:0] tx_byte;
        logic       sda_in;
    } item_t;

    typedef struct packed {
        logic       scl;
        logic       sda_out;
        logic       sda_drive;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_missing;
    } result_t;

    typedef struct packed {
        op_t                active;
        logic [PHASE_W-1:0] phase;
        logic [1:0]         sub;
        logic [7:0]         shift;
        logic [7:0]         wait_cnt;
        logic               scl;
        logic               sda;
        logic               drive;
        logic [7:0]         rcvd;
        logic               ack_fail;
    } eng_state_t;

endpackage

FILE: hdl/i2c_bit_level_master_unit.sv
// ---------------------------------------------------------------------------
// I2C bit-level master unit
// Each input word is one command (start, stop, ack, nack, wait for ack,
// send byte, receive byte, bus reset) or one tick that ends a delay period.
// Every accepted word produces exactly one result word with the SCL, SDA and
// SDA drive levels, busy and done flags, the last received byte and the
// ack-missing flag.
// The input word is registered, the engine applies it once the result register
// has space, and the result is registered together with the new engine state.
// One word is accepted per cycle as long as the result register drains.
// A stalled receiver holds the result register; the input register still
// takes one more word, after which s_ready drops until m_ready returns.
// Configuration writes on cfg_wr_en take effect at once and are meant for
// idle periods only; index 0 is the ack wait limit, index 1 the bus reset
// clock limit.
// Reset empties both registers, idles the engine, releases SCL and SDA high
// in output mode and restores the configuration defaults (5 and 9).
// ---------------------------------------------------------------------------
module i2c_bit_level_master_unit (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic [0:0] cfg_addr,
    input  logic [7:0] cfg_wdata,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [3:0] s_operation,
    input  logic [7:0] s_tx_byte,
    input  logic       s_sda_in,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_scl,
    output logic       m_sda_out,
    output logic       m_sda_drive,
    output logic       m_busy_res,
    output logic       m_done_res,
    output logic [7:0] m_rx_byte,
    output logic       m_ack_missing
);
    import i2cbm_pkg::*;

    item_t   s_item;
    item_t   item;
    logic    item_valid;
    logic    space;
    logic    fire;
    result_t result;
    result_t m_result;

    assign s_item = '{operation: s_operation, tx_byte: s_tx_byte, sda_in: s_sda_in};
    assign fire   = item_valid && space;

    i2cbm_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .take       (fire),
        .item_valid (item_valid),
        .item       (item)
    );

    i2cbm_engine u_eng (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .fire      (fire),
        .item      (item),
        .result    (result)
    );

    i2cbm_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (fire),
        .result   (result),
        .space    (space),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (m_result)
    );

    assign m_scl         = m_result.scl;
    assign m_sda_out     = m_result.sda_out;
    assign m_sda_drive   = m_result.sda_drive;
    assign m_busy_res    = m_result.busy_res;
    assign m_done_res    = m_result.done_res;
    assign m_rx_byte     = m_result.rx_byte;
    assign m_ack_missing = m_result.ack_missing;

endmodule

FILE: hdl/i2cbm_in_stage.sv
// ---------------------------------------------------------------------------
// I2C bit-level master input stage
// Registers one input word and hands it to the engine.
// ---------------------------------------------------------------------------
module i2cbm_in_stage (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  i2cbm_pkg::item_t s_item,
    input  logic            take,
    output logic            item_valid,
    output i2cbm_pkg::item_t item
);
    import i2cbm_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign s_ready    = !valid_reg || take;
    assign valid_next = (s_valid && s_ready) ? 1'b1 : (take ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

FILE: hdl/i2cbm_engine.sv
// ---------------------------------------------------------------------------
// I2C bit-level master engine
// Holds the sequence state and configuration; applies one word per fire.
// ---------------------------------------------------------------------------
module i2cbm_engine (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [0:0]         cfg_addr,
    input  logic [7:0]         cfg_wdata,
    input  logic               fire,
    input  i2cbm_pkg::item_t   item,
    output i2cbm_pkg::result_t result
);
    import i2cbm_pkg::*;

    eng_state_t st_reg;
    eng_state_t st_next;
    logic [7:0] ack_limit_reg;
    logic [3:0] rst_limit_reg;
    logic       done;
    logic [7:0] inc_cnt;
    logic [PHASE_W-1:0] p;

    always_comb begin
        st_next = st_reg;
        done    = 1'b0;
        p       = st_reg.phase;
        inc_cnt = st_reg.wait_cnt + 8'd1;

        if (item.operation == OP_TICK) begin
            if (st_reg.active != OP_TICK) begin
                unique case (st_reg.active)
                    OP_START: begin
                        if (p == '0) begin
                            st_next.sda   = 1'b0;
                            st_next.phase = 5'd1;
                        end else begin
                            st_next.scl = 1'b0;
                            done        = 1'b1;
                        end
                    end
                    OP_STOP: begin
                        if (p == '0) begin
                            st_next.sda   = 1'b1;
                            st_next.phase = 5'd1;
                        end else begin
                            st_next.scl = 1'b0;
                            done        = 1'b1;
                        end
                    end
                    OP_ACK, OP_NACK: begin
                        if (p == '0) begin
                            st_next.scl   = 1'b1;
                            st_next.phase = 5'd1;
                        end else if (p == 5'd1) begin
                            st_next.scl   = 1'b0;
                            st_next.phase = 5'd2;
                        end else begin
                            if (st_reg.active == OP_ACK) begin
                                st_next.sda = 1'b1;
                            end
                            done = 1'b1;
                        end
                    end
                    OP_WAIT: begin
                        if (p == '0) begin
                            st_next.scl   = 1'b1;
                            st_next.phase = 5'd1;
                        end else if (p == 5'd2) begin
                            st_next.drive    = 1'b1;
                            st_next.ack_fail = 1'b0;
                            done             = 1'b1;
                        end else if (p == 5'd4) begin
                            st_next.sda   = 1'b1;
                            st_next.phase = 5'd5;
                        end else if (p == 5'd5) begin
                            st_next.scl      = 1'b0;
                            st_next.ack_fail = 1'b1;
                            done             = 1'b1;
                        end else if (p == 5'd3 && st_reg.wait_cnt == '0) begin
                            st_next.drive = 1'b1;
                            st_next.sda   = 1'b0;
                            st_next.scl   = 1'b1;
                            st_next.phase = 5'd4;
                        end else if (!item.sda_in) begin
                            st_next.scl   = 1'b0;
                            st_next.phase = 5'd2;
                        end else begin
                            st_next.wait_cnt = st_reg.wait_cnt - 8'd1;
                            st_next.phase    = 5'd3;
                        end
                    end
                    OP_SEND: begin
                        if (p >= SEND_LAST_PHASE) begin
                            done = 1'b1;
                        end else begin
                            case (st_reg.sub)
                                2'd0: begin
                                    st_next.sda   = st_reg.shift[7];
                                    st_next.shift = {st_reg.shift[6:0], 1'b0};
                                end
                                2'd1:    st_next.scl = 1'b1;
                                default: st_next.scl = 1'b0;
                            endcase
                            st_next.phase = p + 5'd1;
                            st_next.sub   = (st_reg.sub == SUB_LAST) ? 2'd0 : st_reg.sub + 2'd1;
                        end
                    end
                    OP_RECV: begin
                        if (p >= RECV_LAST_PHASE) begin
                            st_next.drive = 1'b1;
                            st_next.rcvd  = st_reg.shift;
                            done          = 1'b1;
                        end else begin
                            if (!p[0]) begin
                                st_next.shift = {st_reg.shift[6:0], item.sda_in};
                                st_next.scl   = 1'b0;
                            end else begin
                                st_next.scl = 1'b1;
                            end
                            st_next.phase = p + 5'd1;
                        end
                    end
                    OP_RESET: begin
                        if (p == '0) begin
                            st_next.scl   = 1'b0;
                            st_next.phase = 5'd1;
                        end else begin
                            st_next.wait_cnt = inc_cnt;
                            if (item.sda_in || inc_cnt >= {4'd0, rst_limit_reg}) begin
                                done = 1'b1;
                            end else begin
                                st_next.scl   = 1'b1;
                                st_next.phase = '0;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end else if (item.operation <= OP_RESET && st_reg.active == OP_TICK) begin
            st_next.active = op_t'(item.operation);
            st_next.phase  = '0;
            unique case (op_t'(item.operation))
                OP_START: begin
                    st_next.sda = 1'b1;
                    st_next.scl = 1'b1;
                end
                OP_STOP: begin
                    st_next.sda = 1'b0;
                    st_next.scl = 1'b1;
                end
                OP_ACK:  st_next.sda = 1'b0;
                OP_NACK: st_next.sda = 1'b1;
                OP_WAIT: begin
                    st_next.drive    = 1'b0;
                    st_next.wait_cnt = ack_limit_reg;
                end
                OP_SEND: begin
                    st_next.drive = 1'b1;
                    st_next.shift = item.tx_byte;
                    st_next.scl   = 1'b0;
                    st_next.sub   = 2'd0;
                end
                OP_RECV: begin
                    st_next.drive = 1'b0;
                    st_next.shift = '0;
                    st_next.scl   = 1'b1;
                end
                default: begin
                    st_next.wait_cnt = '0;
                    if (rst_limit_reg == '0) begin
                        done = 1'b1;
                    end else begin
                        st_next.scl = 1'b1;
                    end
                end
            endcase
        end

        if (done) begin
            st_next.active = OP_TICK;
            st_next.phase  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg        <= '{active: OP_TICK, phase: '0, sub: '0, shift: '0, wait_cnt: '0,
                               scl: 1'b1, sda: 1'b1, drive: 1'b1, rcvd: '0, ack_fail: 1'b0};
            ack_limit_reg <= ACK_WAIT_RESET;
            rst_limit_reg <= RESET_CLK_RESET;
        end else begin
            if (fire) begin
                st_reg <= st_next;
            end
            if (cfg_wr_en) begin
                unique case (cfg_idx_t'(cfg_addr))
                    CFG_ACK_WAIT_LIMIT:    ack_limit_reg <= cfg_wdata;
                    CFG_RESET_CLOCK_LIMIT: rst_limit_reg <= cfg_wdata[3:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    assign result = '{scl:         st_next.scl,
                      sda_out:     st_next.sda,
                      sda_drive:   st_next.drive,
                      busy_res:    st_next.active != OP_TICK,
                      done_res:    done,
                      rx_byte:     st_next.rcvd,
                      ack_missing: st_next.ack_fail};

endmodule

FILE: hdl/i2cbm_out_stage.sv
// ---------------------------------------------------------------------------
// I2C bit-level master output stage
// Result register with valid and ready toward the receiver.
// ---------------------------------------------------------------------------
module i2cbm_out_stage (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               load,
    input  i2cbm_pkg::result_t result,
    output logic               space,
    output logic               m_valid,
    input  logic               m_ready,
    output i2cbm_pkg::result_t m_result
);
    import i2cbm_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign space      = !valid_reg || m_ready;
    assign valid_next = load ? 1'b1 : (m_ready ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result;
        end
    end

    assign m_valid  = valid_reg;
    assign m_result = result_reg;

endmodule

FILE: hdl/i2cbm_checker.sv
// ---------------------------------------------------------------------------
// I2C bit-level master port checker
// Watches the top-level ports over time and is bound to the top level.
// ---------------------------------------------------------------------------
`include "i2c_bit_level_master_unit_macros.svh"

module i2cbm_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       cfg_wr_en,
    input logic [0:0] cfg_addr,
    input logic [7:0] cfg_wdata,
    input logic       s_valid,
    input logic       s_ready,
    input logic [3:0] s_operation,
    input logic [7:0] s_tx_byte,
    input logic       s_sda_in,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_scl,
    input logic       m_sda_out,
    input logic       m_sda_drive,
    input logic       m_busy_res,
    input logic       m_done_res,
    input logic [7:0] m_rx_byte,
    input logic       m_ack_missing
);

    `I2CBM_ASSERT_NEXT(a_valid_holds, m_valid && !m_ready, m_valid)
    `I2CBM_ASSERT_NEXT(a_rx_holds, m_valid && !m_ready, $stable(m_rx_byte))
    `I2CBM_ASSERT_SAME(a_done_idle, m_valid && m_done_res, !m_busy_res)
    `I2CBM_ASSERT_SAME(a_input_mode_busy, m_valid && !m_sda_drive, m_busy_res)

endmodule

bind i2c_bit_level_master_unit i2cbm_checker u_i2cbm_checker (.*);

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// I2C bit-level master unit testbench
// Feeds command and tick words through the valid/ready input channel in
// random bursts, predicts every result word with a cycle-free model of the
// bit sequencer, and compares each result word field by field while the
// result channel stalls on its own pattern. Directed sequences come first,
// then random well-formed sequences with noise words under several
// settings of the ack wait limit and the bus reset clock limit.
// ---------------------------------------------------------------------------
module testbench;
    import i2cbm_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int PHASE_WORDS = 260;
    localparam logic [3:0] OP_UNUSED_LO = 4'd9;
    localparam logic [3:0] OP_UNUSED_HI = 4'd15;

    typedef enum {SDA_LOW, SDA_HIGH, SDA_ALT, SDA_RANDOM} sda_mode_t;

    typedef struct {
        logic [7:0]         ack_limit;
        logic [3:0]         clk_limit;
        op_t                active;
        logic [PHASE_W-1:0] phase;
        logic [7:0]         shift;
        logic [7:0]         wcount;
        logic               scl;
        logic               sda;
        logic               drive;
        logic [7:0]         rcvd;
        logic               ack_fail;
    } bus_state_t;

    logic       aclk;
    logic       aresetn = 1'b0;
    logic       cfg_wr_en = 1'b0;
    logic [0:0] cfg_addr = CFG_ACK_WAIT_LIMIT;
    logic [7:0] cfg_wdata = 8'd0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [3:0] s_operation = OP_TICK;
    logic [7:0] s_tx_byte = 8'd0;
    logic       s_sda_in = 1'b0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic       m_scl;
    logic       m_sda_out;
    logic       m_sda_drive;
    logic       m_busy_res;
    logic       m_done_res;
    logic [7:0] m_rx_byte;
    logic       m_ack_missing;

    item_t      pending_words[$];
    result_t    expected_results[$];
    bus_state_t model_bus;
    bus_state_t plan_bus;
    item_t      sent_word;
    int         planned_words = 0;
    int         results_seen = 0;
    int         errors = 0;
    int         burst_left = 8;
    int         gap_left = 0;
    int         hold_left = 0;
    int         stall_left = 0;
    int         ready_pct = 100;
    int         cycles = 0;

    i2c_bit_level_master_unit i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_tx_byte     (s_tx_byte),
        .s_sda_in      (s_sda_in),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_scl         (m_scl),
        .m_sda_out     (m_sda_out),
        .m_sda_drive   (m_sda_drive),
        .m_busy_res    (m_busy_res),
        .m_done_res    (m_done_res),
        .m_rx_byte     (m_rx_byte),
        .m_ack_missing (m_ack_missing)
    );

    function automatic bus_state_t bus_reset_state();
        bus_state_t st;
        st.ack_limit = ACK_WAIT_RESET;
        st.clk_limit = RESET_CLK_RESET;
        st.active    = OP_TICK;
        st.phase     = '0;
        st.shift     = 8'd0;
        st.wcount    = 8'd0;
        st.scl       = 1'b1;
        st.sda       = 1'b1;
        st.drive     = 1'b1;
        st.rcvd      = 8'd0;
        st.ack_fail  = 1'b0;
        return st;
    endfunction

    // Applies one word to the sequencer state and returns the result word.
    function automatic result_t bus_step(inout bus_state_t st, input item_t w);
        result_t            r;
        logic               done;
        logic               b;
        logic [PHASE_W-1:0] p;
        done = 1'b0;
        b = w.sda_in;
        p = st.phase;
        if (w.operation == OP_TICK) begin
            if (st.active != OP_TICK) begin
                case (st.active)
                    OP_START, OP_STOP: begin
                        if (p == 0) begin
                            st.sda = (st.active == OP_STOP);
                            st.phase = 1;
                        end else begin
                            st.scl = 1'b0;
                            done = 1'b1;
                        end
                    end
                    OP_ACK, OP_NACK: begin
                        if (p == 0) begin
                            st.scl = 1'b1;
                            st.phase = 1;
                        end else if (p == 1) begin
                            st.scl = 1'b0;
                            st.phase = 2;
                        end else begin
                            if (st.active == OP_ACK) st.sda = 1'b1;
                            done = 1'b1;
                        end
                    end
                    OP_WAIT: begin
                        if (p == 0) begin
                            st.scl = 1'b1;
                            st.phase = 1;
                        end else if (p == 2) begin
                            st.drive = 1'b1;
                            st.ack_fail = 1'b0;
                            done = 1'b1;
                        end else if (p == 3 && st.wcount == 0) begin
                            // Timeout: take the bus back and issue a stop.
                            st.drive = 1'b1;
                            st.sda = 1'b0;
                            st.scl = 1'b1;
                            st.phase = 4;
                        end else if (p == 1 || p == 3) begin
                            if (!b) begin
                                st.scl = 1'b0;
                                st.phase = 2;
                            end else begin
                                st.wcount = st.wcount - 8'd1;
                                st.phase = 3;
                            end
                        end else if (p == 4) begin
                            st.sda = 1'b1;
                            st.phase = 5;
                        end else begin
                            st.scl = 1'b0;
                            st.ack_fail = 1'b1;
                            done = 1'b1;
                        end
                    end
                    OP_SEND: begin
                        if (p >= SEND_LAST_PHASE) begin
                            done = 1'b1;
                        end else begin
                            case (p % 3)
                                0: begin
                                    st.sda = st.shift[7];
                                    st.shift = st.shift << 1;
                                end
                                1: st.scl = 1'b1;
                                default: st.scl = 1'b0;
                            endcase
                            st.phase = p + 1'b1;
                        end
                    end
                    OP_RECV: begin
                        if (p >= RECV_LAST_PHASE) begin
                            st.drive = 1'b1;
                            st.rcvd = st.shift;
                            done = 1'b1;
                        end else begin
                            if (!p[0]) begin
                                st.shift = {st.shift[6:0], b};
                                st.scl = 1'b0;
                            end else begin
                                st.scl = 1'b1;
                            end
                            st.phase = p + 1'b1;
                        end
                    end
                    default: begin
                        if (p == 0) begin
                            st.scl = 1'b0;
                            st.phase = 1;
                        end else begin
                            st.wcount = st.wcount + 8'd1;
                            if (b || st.wcount >= {4'd0, st.clk_limit}) begin
                                done = 1'b1;
                            end else begin
                                st.scl = 1'b1;
                                st.phase = 0;
                            end
                        end
                    end
                endcase
            end
        end else if (w.operation <= OP_RESET && st.active == OP_TICK) begin
            st.active = op_t'(w.operation);
            st.phase = '0;
            case (st.active)
                OP_START: begin
                    st.sda = 1'b1;
                    st.scl = 1'b1;
                end
                OP_STOP: begin
                    st.sda = 1'b0;
                    st.scl = 1'b1;
                end
                OP_ACK: st.sda = 1'b0;
                OP_NACK: st.sda = 1'b1;
                OP_WAIT: begin
                    st.drive = 1'b0;
                    st.wcount = st.ack_limit;
                end
                OP_SEND: begin
                    st.drive = 1'b1;
                    st.shift = w.tx_byte;
                    st.scl = 1'b0;
                end
                OP_RECV: begin
                    st.drive = 1'b0;
                    st.shift = 8'd0;
                    st.scl = 1'b1;
                end
                default: begin
                    st.wcount = 8'd0;
                    if (st.clk_limit == 0) done = 1'b1;
                    else st.scl = 1'b1;
                end
            endcase
        end
        if (done) begin
            st.active = OP_TICK;
            st.phase = '0;
        end
        r.scl         = st.scl;
        r.sda_out     = st.sda;
        r.sda_drive   = st.drive;
        r.busy_res    = (st.active != OP_TICK);
        r.done_res    = done;
        r.rx_byte     = st.rcvd;
        r.ack_missing = st.ack_fail;
        return r;
    endfunction

    function automatic item_t make_word(input logic [3:0] op, input logic [7:0] tx,
                                        input logic b);
        item_t w;
        w.operation = op;
        w.tx_byte = tx;
        w.sda_in = b;
        return w;
    endfunction

    task automatic push_word(input item_t w);
        void'(bus_step(plan_bus, w));
        pending_words.push_back(w);
        planned_words++;
    endtask

    // Ticks the planned sequence to its end, with ignored words mixed in.
    task automatic finish_seq(input sda_mode_t mode, input int noise_pct);
        int   n;
        logic b;
        n = 0;
        while (plan_bus.active != OP_TICK) begin
            if ($urandom_range(1, 100) <= noise_pct)
                push_word(make_word(4'($urandom_range(OP_START, OP_UNUSED_HI)),
                                    8'($urandom), 1'($urandom)));
            case (mode)
                SDA_LOW: b = 1'b0;
                SDA_HIGH: b = 1'b1;
                SDA_ALT: b = n[0];
                default: b = 1'($urandom);
            endcase
            push_word(make_word(OP_TICK, 8'($urandom), b));
            n++;
        end
    endtask

    task automatic run_seq(input op_t op, input logic [7:0] tx, input sda_mode_t mode,
                           input int noise_pct);
        push_word(make_word(op, tx, 1'($urandom)));
        finish_seq(mode, noise_pct);
    endtask

    task automatic random_sequence();
        int        pick;
        sda_mode_t mode;
        pick = $urandom_range(0, 19);
        case ($urandom_range(0, 7))
            0: mode = SDA_LOW;
            1: mode = SDA_HIGH;
            2: mode = SDA_ALT;
            default: mode = SDA_RANDOM;
        endcase
        if (pick == 0)
            push_word(make_word(OP_TICK, 8'($urandom), 1'($urandom)));
        else if (pick == 1)
            push_word(make_word(4'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI)),
                                8'($urandom), 1'($urandom)));
        else
            run_seq(op_t'($urandom_range(OP_START, OP_RESET)), 8'($urandom), mode, 4);
    endtask

    task automatic wait_idle();
        while (pending_words.size() != 0 || expected_results.size() != 0 || s_valid)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [7:0] value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= value;
        if (idx == CFG_ACK_WAIT_LIMIT) begin
            model_bus.ack_limit = value;
            plan_bus.ack_limit = value;
        end else begin
            model_bus.clk_limit = value[3:0];
            plan_bus.clk_limit = value[3:0];
        end
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Input side: words leave the queue in bursts with random gaps.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_operation <= OP_TICK;
            s_tx_byte <= 8'd0;
            s_sda_in <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                expected_results.push_back(bus_step(model_bus, sent_word));
            if (!s_valid || s_ready) begin
                if (gap_left > 0 || pending_words.size() == 0) begin
                    if (gap_left > 0) gap_left--;
                    s_valid <= 1'b0;
                end else begin
                    sent_word = pending_words.pop_front();
                    s_valid <= 1'b1;
                    s_operation <= sent_word.operation;
                    s_tx_byte <= sent_word.tx_byte;
                    s_sda_in <= sent_word.sda_in;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
                                                                 : $urandom_range(1, 40);
                        gap_left = $urandom_range(1, 12);
                    end
                end
            end
        end
    end

    // Result side: checks each word and stalls on its own pattern.
    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    $display("%0t: result word with no expectation, expected none, actual %0h",
                             $time, {m_scl, m_sda_out, m_sda_drive, m_busy_res, m_done_res,
                                     m_rx_byte, m_ack_missing});
                    errors++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("scl", want.scl, m_scl);
                    check_field("sda_out", want.sda_out, m_sda_out);
                    check_field("sda_drive", want.sda_drive, m_sda_drive);
                    check_field("busy_res", want.busy_res, m_busy_res);
                    check_field("done_res", want.done_res, m_done_res);
                    check_field("rx_byte", want.rx_byte, m_rx_byte);
                    check_field("ack_missing", want.ack_missing, m_ack_missing);
                end
                if (results_seen == 300 || results_seen == 1100) hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                if (stall_left == 0) begin
                    stall_left = $urandom_range(5, 60);
                    case ($urandom_range(0, 3))
                        0: ready_pct = 100;
                        1: ready_pct = 75;
                        2: ready_pct = 50;
                        default: ready_pct = 10;
                    endcase
                end
                stall_left--;
                m_ready <= ($urandom_range(1, 100) <= ready_pct);
            end
        end
    end

    initial begin
        int target;
        model_bus = bus_reset_state();
        plan_bus = bus_reset_state();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        for (int ph = 0; ph < 6; ph++) begin
            if (ph > 0) begin
                wait_idle();
                case (ph)
                    1: begin
                        write_reg(CFG_ACK_WAIT_LIMIT, 8'd1);
                        write_reg(CFG_RESET_CLOCK_LIMIT, {4'($urandom), 4'd1});
                    end
                    2: begin
                        write_reg(CFG_ACK_WAIT_LIMIT, 8'd255);
                        write_reg(CFG_RESET_CLOCK_LIMIT, {4'($urandom), 4'd15});
                    end
                    3: begin
                        write_reg(CFG_ACK_WAIT_LIMIT, 8'd0);
                        write_reg(CFG_RESET_CLOCK_LIMIT, {4'($urandom), 4'd0});
                    end
                    default: begin
                        write_reg(CFG_ACK_WAIT_LIMIT, 8'($urandom_range(1, 255)));
                        write_reg(CFG_RESET_CLOCK_LIMIT, 8'($urandom_range(1, 255)));
                    end
                endcase
            end else begin
                push_word(make_word(OP_TICK, 8'hFF, 1'b1));
                push_word(make_word(OP_UNUSED_LO, 8'h00, 1'b0));
                push_word(make_word(OP_UNUSED_HI, 8'hFF, 1'b1));
                // A command and an unknown word while a start is in progress.
                push_word(make_word(OP_START, 8'h00, 1'b0));
                push_word(make_word(OP_SEND, 8'h3C, 1'b1));
                push_word(make_word(OP_UNUSED_HI, 8'hFF, 1'b0));
                finish_seq(SDA_RANDOM, 0);
                run_seq(OP_SEND, 8'hFF, SDA_RANDOM, 0);
                run_seq(OP_SEND, 8'h00, SDA_RANDOM, 0);
                run_seq(OP_WAIT, 8'h00, SDA_LOW, 0);
                run_seq(OP_WAIT, 8'hFF, SDA_HIGH, 0);
                run_seq(OP_RECV, 8'h00, SDA_ALT, 0);
                run_seq(OP_RECV, 8'h00, SDA_HIGH, 0);
                run_seq(OP_RECV, 8'hFF, SDA_LOW, 0);
                run_seq(OP_ACK, 8'h00, SDA_RANDOM, 0);
                run_seq(OP_NACK, 8'h00, SDA_RANDOM, 0);
                run_seq(OP_STOP, 8'h00, SDA_RANDOM, 0);
                run_seq(OP_RESET, 8'h00, SDA_LOW, 0);
                run_seq(OP_RESET, 8'h00, SDA_HIGH, 0);
            end
            target = planned_words + PHASE_WORDS;
            while (planned_words < target) random_sequence();
        end

        wait_idle();
        repeat (10) @(negedge aclk);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
